// ----- rtl/linear_key_value_table_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the linear key-value table
// Concurrent checks clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef LINEAR_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define LINEAR_KEY_VALUE_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LKVT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LKVT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LKVT_ASSERT_IMP(lbl, ante, cons, msg)
`define LKVT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/lkvt_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvt_pkg
// Shared constants and types of the linear key-value table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkvt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] COUNT_ONE  = CNT_W'(1);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [63:0] key;
    logic signed [63:0] new_value;
  } req_t;

  typedef struct packed {
    logic               status;
    logic               found;
    logic signed [63:0] old_value;
    logic [3:0]         entry_index;
    logic [4:0]         entry_count;
  } rsp_t;

  // search token passed cell to cell
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] slot;
    logic [63:0]      value;
    logic [63:0]      last_key;
    logic [63:0]      last_value;
  } probe_t;

  // broadcast write into one cell
  typedef struct packed {
    logic             en;
    logic             set_key;
    logic [IDX_W-1:0] idx;
    logic [63:0]      key;
    logic [63:0]      value;
  } cell_wr_t;

endpackage

`default_nettype wire

// ----- rtl/lkvt_cell.sv -----
// ----------------------------------------------------------------------------
// lkvt_cell
// One table slot: holds a key and a value, checks the passing search token
// against its key and forwards the token to the next slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkvt_cell import lkvt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] index,
  input  logic [CNT_W-1:0] count,
  input  logic [63:0]      key,
  input  probe_t           probe_in,
  input  cell_wr_t         wr,
  output probe_t           probe_out
);

  logic [63:0] stored_key;
  logic [63:0] stored_value;
  logic        live;
  logic        match;
  logic        is_last;
  probe_t      probe_next;

  assign live    = CNT_W'(index) < count;
  assign is_last = (CNT_W'(index) + COUNT_ONE) == count;
  assign match   = probe_in.valid && !probe_in.hit && live && (stored_key == key);

  always_comb begin
    probe_next = probe_in;
    if (match) begin
      probe_next.hit   = 1'b1;
      probe_next.slot  = index;
      probe_next.value = stored_value;
    end
    if (is_last) begin
      probe_next.last_key   = stored_key;
      probe_next.last_value = stored_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out <= probe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == index)) begin
      if (wr.set_key) begin
        stored_key <= wr.key;
      end
      stored_value <= wr.value;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/linear_key_value_table_top.sv -----
// ----------------------------------------------------------------------------
// linear_key_value_table_top
// Key-value table of signed 64-bit pairs kept packed below a fill count;
// insert, lookup and remove searched by a token running along a row of slots.
//
//   channel  | port group                    | payload
//   request  | req_valid / req_stall / req   | req_t  (kind, key, new_value)
//   response | rsp_valid / rsp_stall / rsp   | rsp_t  (status .. entry_count)
//
// A request launches a search token that crosses all ENTRIES slot registers;
// the result is then latched, and the update is made and the response registered.
// A new request is taken while the previous response waits in its register;
// its update then holds until that response transfers.
// rst clears the fill count and all control; slot contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_key_value_table_top_assert.svh"

module linear_key_value_table_top import lkvt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  req_t             req_q;
  logic             launch;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  probe_t           res;
  probe_t           chain [0:ENTRIES];
  cell_wr_t         wr;
  cell_wr_t         cell_wr;
  rsp_t             rsp_next;
  logic             accept;
  logic             do_update;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign do_update = (state == S_UPDATE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkvt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .index     (IDX_W'(g)),
      .count     (fill_count),
      .key       (req_q.key),
      .probe_in  (chain[g]),
      .wr        (cell_wr),
      .probe_out (chain[g+1])
    );
  end

  always_comb begin
    wr              = '0;
    rsp_next        = '0;
    fill_count_next = fill_count;
    case (req_q.kind)
      KIND_INSERT: begin
        if (res.hit) begin
          wr.en              = 1'b1;
          wr.idx             = res.slot;
          wr.value           = req_q.new_value;
          rsp_next.found     = 1'b1;
          rsp_next.old_value = res.value;
        end else if (fill_count == FULL_COUNT) begin
          rsp_next.status = 1'b1;
        end else begin
          wr.en           = 1'b1;
          wr.set_key      = 1'b1;
          wr.idx          = fill_count[IDX_W-1:0];
          wr.key          = req_q.key;
          wr.value        = req_q.new_value;
          fill_count_next = fill_count + COUNT_ONE;
        end
      end
      KIND_LOOKUP: begin
        if (res.hit) begin
          rsp_next.found     = 1'b1;
          rsp_next.old_value = res.value;
        end
      end
      KIND_REMOVE: begin
        if (res.hit) begin
          wr.en              = 1'b1;
          wr.set_key         = 1'b1;
          wr.idx             = res.slot;
          wr.key             = res.last_key;
          wr.value           = res.last_value;
          rsp_next.found     = 1'b1;
          rsp_next.old_value = res.value;
          fill_count_next    = fill_count - COUNT_ONE;
        end
      end
      default: ;
    endcase
    if (rsp_next.found) begin
      rsp_next.entry_index = 4'(res.slot);
    end
    rsp_next.entry_count = 5'(fill_count_next);
  end

  always_comb begin
    cell_wr    = wr;
    cell_wr.en = wr.en && do_update;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SEARCH;
      S_SEARCH: if (chain[ENTRIES].valid) state_next = S_UPDATE;
      S_UPDATE: if (do_update) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      launch     <= 1'b0;
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
      if (do_update) begin
        fill_count <= fill_count_next;
        rsp_valid  <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if ((state == S_SEARCH) && chain[ENTRIES].valid) begin
      res <= chain[ENTRIES];
    end
    if (do_update) begin
      rsp <= rsp_next;
    end
  end

  `LKVT_ASSERT_IMP(a_count_range, 1'b1, fill_count <= FULL_COUNT, "fill count beyond capacity")
  `LKVT_ASSERT_NXT(a_accept_search, accept, state == S_SEARCH && launch, "search not started")
  `LKVT_ASSERT_IMP(a_full_refusal, rsp_valid && rsp.status, !rsp.found && fill_count == FULL_COUNT, "refusal while not full")

endmodule

`default_nettype wire

// ----- bench/tb_linear_key_value_table_top.sv -----
// ----------------------------------------------------------------------------
// tb_linear_key_value_table_top
// Self-checking bench for the linear key-value table. A scoreboard keeps its
// own copy of the table, works out the response for every accepted request
// and compares each response transfer field by field. Directed requests hit
// the empty, full, overwrite, miss and remove-move cases. They are followed
// by random fill and drain phases over a small key pool, with random idling
// on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_key_value_table_top;
  import lkvt_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;
  localparam logic signed [63:0] KEY_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] KEY_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam int POOL_SIZE    = 20;
  localparam int IDLE_PCT     = 29;
  localparam int RANDOM_ITEMS = 830;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTS   = 100;

  class kv_scoreboard;
    logic signed [63:0] keys_at[ENTRIES];
    logic signed [63:0] values_at[ENTRIES];
    int unsigned fill;
    rsp_t pending[$];
    int errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t exp;
      int slot;
      bit hit;
      exp = '0;
      exp.status = STATUS_DONE;
      slot = 0;
      hit = 1'b0;
      if (r.kind != KIND_NOP) begin
        for (int i = 0; i < fill; i++) begin
          if (!hit && keys_at[i] == r.key) begin
            hit = 1'b1;
            slot = i;
          end
        end
      end
      case (r.kind)
        KIND_INSERT: begin
          if (hit) begin
            exp.found = 1'b1;
            exp.old_value = values_at[slot];
            values_at[slot] = r.new_value;
          end else if (fill >= ENTRIES) begin
            exp.status = STATUS_FULL;
          end else begin
            keys_at[fill] = r.key;
            values_at[fill] = r.new_value;
            fill++;
          end
        end
        KIND_LOOKUP: begin
          if (hit) begin
            exp.found = 1'b1;
            exp.old_value = values_at[slot];
          end
        end
        KIND_REMOVE: begin
          if (hit) begin
            exp.found = 1'b1;
            exp.old_value = values_at[slot];
            // last entry fills the hole
            if (slot != fill - 1) begin
              keys_at[slot] = keys_at[fill-1];
              values_at[slot] = values_at[fill-1];
            end
            fill--;
          end
        end
        default: begin
        end
      endcase
      exp.entry_index = hit ? 4'(slot) : 4'd0;
      exp.entry_count = 5'(fill);
      pending.push_back(exp);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_response(rsp_t got);
      rsp_t exp;
      if (pending.size() == 0) begin
        report($sformatf("response with none outstanding: %p", got));
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0b, want %0b", got.status, exp.status));
      if (got.found !== exp.found)
        report($sformatf("found %0b, want %0b", got.found, exp.found));
      if (got.old_value !== exp.old_value)
        report($sformatf("old_value %h, want %h", got.old_value, exp.old_value));
      if (got.entry_index !== exp.entry_index)
        report($sformatf("entry_index %0d, want %0d", got.entry_index, exp.entry_index));
      if (got.entry_count !== exp.entry_count)
        report($sformatf("entry_count %0d, want %0d", got.entry_count, exp.entry_count));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  bit idling_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  kv_scoreboard sb = new();

  linear_key_value_table_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // response side: check each transfer, then pick the next stall
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= idling_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  function automatic logic signed [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic signed [63:0] key,
                              input logic signed [63:0] value);
    req_t r;
    int gap;
    r.kind = kind;
    r.key = key;
    r.new_value = value;
    gap = 0;
    while (idling_on && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  initial begin
    logic signed [63:0] key_pool[POOL_SIZE];
    logic signed [63:0] key;
    logic signed [63:0] value;
    logic [1:0] kind;
    bit filling;
    int roll;
    int ins_cut;
    int look_cut;

    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = -64'sd1;
    key_pool[4] = 64'sd1;
    key_pool[5] = 64'sh5555_5555_5555_5555;
    key_pool[6] = 64'shaaaa_aaaa_aaaa_aaaa;
    for (int i = 7; i < POOL_SIZE; i++) key_pool[i] = rand64();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_request(KIND_LOOKUP, 64'sd5, rand64());
    send_request(KIND_REMOVE, KEY_MIN, rand64());
    send_request(KIND_NOP, -64'sd1, -64'sd1);
    send_request(KIND_INSERT, KEY_MIN, KEY_MAX);
    send_request(KIND_INSERT, KEY_MAX, KEY_MIN);
    send_request(KIND_INSERT, -64'sd1, -64'sd1);
    send_request(KIND_INSERT, KEY_MIN, '0);
    send_request(KIND_LOOKUP, KEY_MAX, rand64());
    send_request(KIND_REMOVE, -64'sd1, rand64());
    send_request(KIND_REMOVE, KEY_MIN, rand64());
    send_request(KIND_LOOKUP, KEY_MAX, rand64());
    while (sb.fill < ENTRIES) send_request(KIND_INSERT, rand64(), rand64());
    send_request(KIND_INSERT, '0, rand64());
    send_request(KIND_INSERT, KEY_MAX, 64'sd1);

    // random fill and drain phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) idling_on <= 1'b0;
      if (n == 300) idling_on <= 1'b1;
      if (n == 450) hold_req <= 1'b1;
      if (n % 140 == 139) begin
        repeat (3) key_pool[$urandom_range(7, POOL_SIZE - 1)] = rand64();
      end
      filling = ((n / 70) % 2) == 0;
      ins_cut = filling ? 58 : 28;
      look_cut = ins_cut + 20;
      roll = $urandom_range(0, 99);
      if (roll < 3) kind = KIND_NOP;
      else if (roll < ins_cut) kind = KIND_INSERT;
      else if (roll < look_cut) kind = KIND_LOOKUP;
      else kind = KIND_REMOVE;
      roll = $urandom_range(0, 99);
      if (kind != KIND_INSERT && sb.fill > 0 && roll < 40)
        key = sb.keys_at[$urandom_range(0, sb.fill - 1)];
      else if (roll < 92)
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        key = rand64();
      roll = $urandom_range(0, 99);
      if (roll < 5) value = KEY_MIN;
      else if (roll < 10) value = KEY_MAX;
      else value = rand64();
      send_request(kind, key, value);
    end
    req_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
